@@ sv/psc_pkg.sv @@
// Shared types and constants for the PID slew clamp controller.
// Used by the bit-serial arithmetic units and the top level; depends on nothing.
package psc_pkg;

   localparam int GAIN_W      = 24;
   localparam int SLEW_W      = 15;
   localparam int TARGET_W    = 32;
   localparam int BAND_W      = 31;
   localparam int POWER_W     = 16;
   localparam int MEAS_W      = 32;
   localparam int ERROR_OUT_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Product magnitudes saturate at this limit.
   localparam int PROD_W = 62;
   localparam logic [PROD_W-1:0] PROD_LIMIT = 62'h2000_0000_0000_0000;

   localparam logic [GAIN_W-1:0] KP_RESET   = 24'd78643;
   localparam logic [GAIN_W-1:0] KI_RESET   = 24'd0;
   localparam logic [GAIN_W-1:0] KD_RESET   = 24'd655;
   localparam logic [SLEW_W-1:0] SLEW_RESET = 15'd1638;
   localparam logic [BAND_W-1:0] BAND_RESET = 31'd13107;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KP_GAIN    = 3'd0,
      CSR_KI_GAIN    = 3'd1,
      CSR_KD_GAIN    = 3'd2,
      CSR_SLEW_STEP  = 3'd3,
      CSR_TARGET     = 3'd4,
      CSR_STOP_BAND  = 3'd5,
      CSR_SWITCH_EN  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } psc_unit_stat_type;

endpackage

@@ sv/psc_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on psc_pkg for the divisor width and the status struct.
module psc_div import psc_pkg::*; #(
   parameter int QW = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [QW-1:0]       dividend,
   input  logic [TARGET_W-1:0] divisor,
   output logic [QW-1:0]       quotient,
   output psc_unit_stat_type   stat
);

   localparam int CNT_W = $clog2(QW);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [TARGET_W-1:0] rem_ff;
   logic [TARGET_W-1:0] div_ff;
   logic [QW-1:0]       quo_ff;
   logic [TARGET_W:0]   rem_sh;
   logic                ge;
   logic [TARGET_W-1:0] rem_in;
   logic [QW-1:0]       quo_in;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[QW-1]};
      ge     = rem_sh >= {1'b0, div_ff};
      rem_in = ge ? TARGET_W'(rem_sh - {1'b0, div_ff}) : rem_sh[TARGET_W-1:0];
      quo_in = {quo_ff[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            div_ff  <= divisor;
            quo_ff  <= dividend;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ sv/psc_mul.sv @@
// Bit-serial saturating multiplier, one gain bit per cycle, MSB first.
// Depends on psc_pkg for the gain width, product limit and status struct.
module psc_mul import psc_pkg::*; #(
   parameter int MAG_W = 49
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [GAIN_W-1:0] gain,
   input  logic [MAG_W-1:0]  mag,
   output logic [PROD_W-1:0] product,
   output psc_unit_stat_type stat
);

   localparam int CNT_W = $clog2(GAIN_W);
   localparam int SUM_W = (MAG_W > PROD_W) ? MAG_W + 2 : PROD_W + 2;

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [MAG_W-1:0]  mag_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [PROD_W-1:0] product_ff;
   logic [SUM_W-1:0]  step_sum;
   logic [PROD_W-1:0] acc_in;

   // Once the running value passes the limit it stays marked as over it.
   always_comb begin
      step_sum = SUM_W'({acc_ff, 1'b0})
               + (gain_ff[GAIN_W-1] ? SUM_W'(mag_ff) : SUM_W'(0));
      acc_in   = (step_sum > SUM_W'(PROD_LIMIT)) ? PROD_LIMIT + 1'b1
                                                 : step_sum[PROD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            gain_ff <= gain;
            mag_ff  <= mag;
            acc_ff  <= '0;
         end else if (busy_ff) begin
            acc_ff  <= acc_in;
            gain_ff <= {gain_ff[GAIN_W-2:0], 1'b0};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(GAIN_W - 1)) begin
               busy_ff    <= 1'b0;
               done_ff    <= 1'b1;
               product_ff <= (acc_in > PROD_LIMIT) ? PROD_LIMIT : acc_in;
            end
         end
      end
   end

   assign product   = product_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ sv/pid_slew_clamp_controller.sv @@
// PID position loop with slew limit and Q1.15 clamp; top level.
// The result is computed by the bit-serial divider and three serial multiplies (P, I, D);
// a zero setpoint skips the divider, and once the run is done both are skipped. One item
// is processed at a time: a new item is accepted only after the previous result has been
// registered for output and the state machine is back in idle.
// Reset is synchronous, active high, restores register defaults and clears the loop state.
module pid_slew_clamp_controller import psc_pkg::*; #(
   parameter int DATA_WIDTH = 32,
   parameter int SUM_WIDTH  = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [MEAS_W-1:0]      req_tdata,   // measured_position
   input  logic                   req_tuser,   // limit_switch
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [47:0]            rsp_tdata,   // drive_power, error_value
   output logic                   rsp_tuser,   // run_done
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int QW    = DATA_WIDTH + 16;
   localparam int MAG_W = (SUM_WIDTH > DATA_WIDTH + 1) ? SUM_WIDTH : DATA_WIDTH + 1;

   localparam logic signed [64:0] ERR_HI = (65'sd1 <<< (DATA_WIDTH - 1)) - 65'sd1;
   localparam logic signed [64:0] ERR_LO = -ERR_HI - 65'sd1;
   localparam logic signed [64:0] SUM_HI = (65'sd1 <<< (SUM_WIDTH - 1)) - 65'sd1;
   localparam logic signed [64:0] SUM_LO = -SUM_HI - 65'sd1;
   localparam logic signed [64:0] EV_HI  = 65'sd2147483647;
   localparam logic signed [64:0] EV_LO  = -EV_HI - 65'sd1;
   localparam logic [QW-1:0] P_POS_MAX = QW'((65'd1 << (DATA_WIDTH - 1)) - 65'd1);
   localparam logic [QW-1:0] P_NEG_MAX = QW'(65'd1 << (DATA_WIDTH - 1));
   localparam logic signed [63:0] PW_HI = 64'sd32767;
   localparam logic signed [63:0] PW_LO = -64'sd32768;

   typedef enum logic [2:0] {
      S_IDLE, S_EVAL, S_DIV, S_MUL_P, S_MUL_I, S_MUL_D, S_SLEW, S_OUT
   } state_type;

   state_type state_ff;

   logic [GAIN_W-1:0]          kp_ff, ki_ff, kd_ff;
   logic [SLEW_W-1:0]          slew_ff;
   logic signed [TARGET_W-1:0] target_ff;
   logic [BAND_W-1:0]          band_ff;
   logic                       switch_en_ff;

   logic signed [MEAS_W-1:0]     meas_ff;
   logic                         sw_ff;
   logic signed [DATA_WIDTH-1:0] err_ff;
   logic [DATA_WIDTH-1:0]        emag_ff;
   logic                         done_hit_ff;
   logic signed [SUM_WIDTH-1:0]  error_sum_ff;
   logic signed [DATA_WIDTH-1:0] last_error_ff;
   logic signed [POWER_W-1:0]    last_power_ff;
   logic                         finished_ff;
   logic signed [63:0]           acc_ff;

   logic              div_start_ff;
   logic              mul_start_ff;
   logic [GAIN_W-1:0] mul_gain_ff;
   logic [MAG_W-1:0]  mul_mag_ff;
   logic              mul_neg_ff;

   logic        rsp_tvalid_ff;
   logic [47:0] rsp_tdata_ff;
   logic        rsp_tuser_ff;

   psc_unit_stat_type div_stat, mul_stat;
   logic [QW-1:0]     quotient;
   logic [PROD_W-1:0] product;

   logic signed [64:0] diff_w, err_w, esum_w, esum_sat_w, esum_cur_w, deriv_w, ev_w;
   logic [64:0]        emag_w, esum_mag_w, deriv_mag_w, tmag_w;
   logic [QW-1:0]      pmag_q;
   logic               pneg;
   logic signed [63:0] prod_s, pw0, pw1, pw2, lp_w, ss_w;

   always_comb begin
      diff_w     = 65'(target_ff) - 65'(meas_ff);
      err_w      = (diff_w > ERR_HI) ? ERR_HI : ((diff_w < ERR_LO) ? ERR_LO : diff_w);
      emag_w     = (err_w < 0) ? 65'(-err_w) : 65'(err_w);
      esum_w     = 65'(error_sum_ff) + err_w;
      esum_sat_w = (esum_w > SUM_HI) ? SUM_HI : ((esum_w < SUM_LO) ? SUM_LO : esum_w);
      esum_cur_w = 65'(error_sum_ff);
      esum_mag_w = (esum_cur_w < 0) ? 65'(-esum_cur_w) : 65'(esum_cur_w);
      deriv_w    = 65'(err_ff) - 65'(last_error_ff);
      deriv_mag_w = (deriv_w < 0) ? 65'(-deriv_w) : 65'(deriv_w);
      ev_w       = 65'(err_ff);
      ev_w       = (ev_w > EV_HI) ? EV_HI : ((ev_w < EV_LO) ? EV_LO : ev_w);
      tmag_w     = (target_ff < 0) ? 65'(-65'(target_ff)) : 65'(target_ff);

      if (target_ff < 0) begin
         pmag_q = (quotient > P_NEG_MAX) ? P_NEG_MAX : quotient;
         pneg   = quotient != '0;
      end else begin
         pmag_q = (quotient > P_POS_MAX) ? P_POS_MAX : quotient;
         pneg   = 1'b0;
      end

      prod_s = mul_neg_ff ? -signed'(64'(product)) : signed'(64'(product));

      lp_w = 64'(last_power_ff);
      ss_w = signed'(64'(slew_ff));
      pw0  = acc_ff >>> 17;
      pw1  = (pw0 > lp_w + ss_w) ? lp_w + ss_w
                                 : ((pw0 < lp_w - ss_w) ? lp_w - ss_w : pw0);
      pw2  = (pw1 > PW_HI) ? PW_HI : ((pw1 < PW_LO) ? PW_LO : pw1);
   end

   psc_div #(.QW(QW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend ({emag_ff, 16'b0}),
      .divisor  (tmag_w[TARGET_W-1:0]),
      .quotient (quotient),
      .stat     (div_stat)
   );

   psc_mul #(.MAG_W(MAG_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .gain    (mul_gain_ff),
      .mag     (mul_mag_ff),
      .product (product),
      .stat    (mul_stat)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= KP_RESET;
         ki_ff        <= KI_RESET;
         kd_ff        <= KD_RESET;
         slew_ff      <= SLEW_RESET;
         target_ff    <= '0;
         band_ff      <= BAND_RESET;
         switch_en_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KP_GAIN:   kp_ff        <= csr_data[GAIN_W-1:0];
            CSR_KI_GAIN:   ki_ff        <= csr_data[GAIN_W-1:0];
            CSR_KD_GAIN:   kd_ff        <= csr_data[GAIN_W-1:0];
            CSR_SLEW_STEP: slew_ff      <= csr_data[SLEW_W-1:0];
            CSR_TARGET:    target_ff    <= csr_data[TARGET_W-1:0];
            CSR_STOP_BAND: band_ff      <= csr_data[BAND_W-1:0];
            CSR_SWITCH_EN: switch_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !div_stat.busy && !mul_stat.busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         div_start_ff  <= 1'b0;
         mul_start_ff  <= 1'b0;
         error_sum_ff  <= '0;
         last_error_ff <= '0;
         last_power_ff <= '0;
         finished_ff   <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  meas_ff  <= req_tdata;
                  sw_ff    <= req_tuser;
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               err_ff      <= err_w[DATA_WIDTH-1:0];
               emag_ff     <= emag_w[DATA_WIDTH-1:0];
               done_hit_ff <= (emag_w <= 65'(band_ff)) || (sw_ff && switch_en_ff);
               if (finished_ff) begin
                  state_ff <= S_OUT;
               end else begin
                  error_sum_ff <= esum_sat_w[SUM_WIDTH-1:0];
                  acc_ff       <= '0;
                  if (target_ff == '0) begin
                     mul_gain_ff  <= kp_ff;
                     mul_mag_ff   <= (emag_w != '0) ? MAG_W'(P_POS_MAX) : '0;
                     mul_neg_ff   <= 1'b0;
                     mul_start_ff <= 1'b1;
                     state_ff     <= S_MUL_P;
                  end else begin
                     div_start_ff <= 1'b1;
                     state_ff     <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               if (div_stat.done) begin
                  mul_gain_ff  <= kp_ff;
                  mul_mag_ff   <= MAG_W'(pmag_q);
                  mul_neg_ff   <= pneg;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_MUL_P;
               end
            end
            S_MUL_P: begin
               if (mul_stat.done) begin
                  acc_ff       <= acc_ff + prod_s;
                  mul_gain_ff  <= ki_ff;
                  mul_mag_ff   <= esum_mag_w[MAG_W-1:0];
                  mul_neg_ff   <= error_sum_ff < 0;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_MUL_I;
               end
            end
            S_MUL_I: begin
               if (mul_stat.done) begin
                  acc_ff       <= acc_ff + prod_s;
                  mul_gain_ff  <= kd_ff;
                  mul_mag_ff   <= deriv_mag_w[MAG_W-1:0];
                  mul_neg_ff   <= deriv_w < 0;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_MUL_D;
               end
            end
            S_MUL_D: begin
               if (mul_stat.done) begin
                  acc_ff   <= acc_ff + prod_s;
                  state_ff <= S_SLEW;
               end
            end
            S_SLEW: begin
               last_power_ff <= pw2[POWER_W-1:0];
               last_error_ff <= err_ff;
               finished_ff   <= done_hit_ff;
               state_ff      <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tdata_ff  <= {ev_w[ERROR_OUT_W-1:0],
                                    finished_ff ? POWER_W'(0) : last_power_ff};
                  rsp_tuser_ff  <= finished_ff;
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

@@ sv/psc_checker.sv @@
// Port-level checks for the PID slew clamp controller, bound to the top level.
// Depends only on the top level's ports.
module psc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic [1:0] pending_ff;
   logic       done_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         done_seen_ff <= 1'b0;
      end else begin
         pending_ff <= pending_ff + 2'((req_tvalid && req_tready) ? 1 : 0)
                                  - 2'((rsp_tvalid && rsp_tready) ? 1 : 0);
         if (rsp_tvalid && rsp_tready && rsp_tuser) begin
            done_seen_ff <= 1'b1;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:0] == 16'd0)
      else $error("drive power nonzero after run done");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_seen_ff && rsp_tvalid |-> rsp_tuser)
      else $error("run done flag cleared");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("result transfer without a pending input");

endmodule

bind pid_slew_clamp_controller psc_checker u_psc_checker (.*);

@@ tb/sv/pid_slew_clamp_controller_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pid_slew_clamp_controller: random and directed
// measurements are checked against a built-in model of the PID, slew and clamp logic.
// Depends on psc_pkg and the controller RTL.
module pid_slew_clamp_controller_test;
   import psc_pkg::*;

   typedef struct {
      logic [MEAS_W-1:0] position;
      logic              limit_hit;
   } tick_type;

   typedef struct {
      logic signed [POWER_W-1:0]     power;
      logic                          done;
      logic signed [ERROR_OUT_W-1:0] error;
   } drive_type;

   localparam longint ERR_MAX   = 64'sd2147483647;
   localparam longint ERR_MIN   = -64'sd2147483648;
   localparam longint SUM_MAX   = (64'sd1 <<< 47) - 1;
   localparam longint SUM_MIN   = -(64'sd1 <<< 47);
   localparam longint CYCLE_CAP = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [MEAS_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   pid_slew_clamp_controller u_dut (.*);

   // Controller model state and register copy.
   logic [GAIN_W-1:0] kp, ki, kd;
   logic [SLEW_W-1:0] slew;
   logic signed [TARGET_W-1:0] setpoint;
   logic [BAND_W-1:0] band;
   logic switch_en;
   longint err_sum, prev_err, prev_power;
   logic run_over;

   tick_type  tick_q[$];
   drive_type drive_q[$];
   int        fail_count = 0;
   longint    cycles = 0;
   bit        no_idle = 0;
   int        req_gap = 0;
   int        rsp_gap = 0;

   initial forever #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic longint sat_to(longint v, longint hi, longint lo);
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   function automatic longint scale_gain(logic [GAIN_W-1:0] g, longint x);
      longint unsigned m, p;
      m = (x < 0) ? -x : x;
      if (g != 0 && m > 64'h2000_0000_0000_0000 / g) p = 64'h2000_0000_0000_0000;
      else p = m * g;
      return (x < 0) ? -longint'(p) : longint'(p);
   endfunction

   function automatic drive_type advance_loop(tick_type t);
      drive_type d;
      longint err, prop, deriv, total, pw;
      longint unsigned emag, quot;
      err  = sat_to(longint'(setpoint) - longint'($signed(t.position)), ERR_MAX, ERR_MIN);
      emag = (err < 0) ? -err : err;
      d.power = '0;
      if (!run_over) begin
         if (setpoint == 0) begin
            prop = (emag != 0) ? ERR_MAX : 0;
         end else begin
            quot = (emag << 16) / ((setpoint < 0) ? -longint'(setpoint) : longint'(setpoint));
            prop = (setpoint < 0) ? -longint'(quot) : longint'(quot);
            prop = sat_to(prop, ERR_MAX, ERR_MIN);
         end
         err_sum = sat_to(err_sum + err, SUM_MAX, SUM_MIN);
         deriv   = err - prev_err;
         total   = scale_gain(kp, prop) + scale_gain(ki, err_sum) + scale_gain(kd, deriv);
         pw      = total >>> 17;
         pw      = sat_to(pw, prev_power + slew, prev_power - slew);
         pw      = sat_to(pw, 32767, -32768);
         prev_err   = err;
         prev_power = pw;
         d.power    = pw[POWER_W-1:0];
         if (emag <= band || (t.limit_hit && switch_en)) run_over = 1'b1;
      end
      if (run_over) d.power = '0;
      d.done  = run_over;
      d.error = err[31:0];
      return d;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      fail_count++;
   endtask

   // Request driver.
   always @(posedge clock) begin
      tick_type t;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            t.position  = req_tdata;
            t.limit_hit = req_tuser;
            drive_q.push_back(advance_loop(t));
            req_gap = pick_gap();
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (tick_q.size() > 0) begin
               t = tick_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= t.position;
               req_tuser  <= t.limit_hit;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      drive_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (drive_q.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_tdata[15:0], 0);
            end else begin
               want = drive_q.pop_front();
               if (rsp_tdata[15:0] !== want.power)
                  report_mismatch("drive_power", $signed(rsp_tdata[15:0]), want.power);
               if (rsp_tuser !== want.done)
                  report_mismatch("run_done", rsp_tuser, want.done);
               if (rsp_tdata[47:16] !== want.error)
                  report_mismatch("error_value", $signed(rsp_tdata[47:16]), want.error);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready) rsp_gap = pick_gap();
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_KP_GAIN:   kp = val[GAIN_W-1:0];
         CSR_KI_GAIN:   ki = val[GAIN_W-1:0];
         CSR_KD_GAIN:   kd = val[GAIN_W-1:0];
         CSR_SLEW_STEP: slew = val[SLEW_W-1:0];
         CSR_TARGET:    setpoint = val;
         CSR_STOP_BAND: band = val[BAND_W-1:0];
         CSR_SWITCH_EN: switch_en = val[0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (tick_q.size() != 0 || req_tvalid || drive_q.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic push_tick(logic [MEAS_W-1:0] pos, logic hit);
      tick_type t;
      t.position  = pos;
      t.limit_hit = hit;
      tick_q.push_back(t);
   endtask

   // Picks a position whose error stays outside the stop band.
   task automatic push_running_tick(logic hit);
      logic [MEAS_W-1:0] pos;
      longint err;
      do begin
         if ($urandom_range(0, 9) < 6)
            pos = setpoint - $signed($urandom_range(0, 2097152) - 1048576);
         else
            pos = $urandom();
         err = sat_to(longint'(setpoint) - longint'($signed(pos)), ERR_MAX, ERR_MIN);
      end while (((err < 0) ? -err : err) <= band);
      push_tick(pos, hit);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return GAIN_W'($urandom_range(0, 255));
         default: return GAIN_W'($urandom_range(0, 200000));
      endcase
   endfunction

   initial begin
      logic hit;
      kp = KP_RESET; ki = KI_RESET; kd = KD_RESET; slew = SLEW_RESET;
      setpoint = '0; band = BAND_RESET; switch_en = 1'b0;
      err_sum = 0; prev_err = 0; prev_power = 0; run_over = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, zero setpoint, saturating errors, ignored limit switch.
      push_tick(32'h7FFF_FFFF, 1'b0);
      push_tick(32'h8000_0000, 1'b1);
      push_tick(32'h0010_0000, 1'b1);
      push_tick(32'hFFF0_0000, 1'b0);
      push_tick(32'hFFFF_0000, 1'b0);
      wait_drained();

      write_reg(CSR_STOP_BAND, '0);
      write_reg(CSR_KP_GAIN, 32'h00FF_FFFF);
      write_reg(CSR_KI_GAIN, 32'h00FF_FFFF);
      write_reg(CSR_KD_GAIN, 32'h00FF_FFFF);
      write_reg(CSR_SLEW_STEP, 32'h7FFF);
      write_reg(CSR_TARGET, 32'h7FFF_FFFF);
      write_reg(csr_index_type'(3'd7), 32'hFFFF_FFFF);
      push_tick(32'h8000_0000, 1'b0);
      push_tick(32'h8000_0001, 1'b1);
      push_tick(32'h0000_0000, 1'b0);
      push_tick(32'h7FFF_FFFE, 1'b0);
      wait_drained();
      write_reg(CSR_TARGET, 32'h8000_0000);
      write_reg(CSR_SLEW_STEP, '0);
      push_tick(32'h7FFF_FFFF, 1'b0);
      push_tick(32'h0000_0001, 1'b1);
      wait_drained();
      write_reg(CSR_SLEW_STEP, 32'h7FFF);
      write_reg(CSR_KI_GAIN, '0);
      push_tick(32'h7FFF_FFFF, 1'b0);
      push_tick(32'h8000_0001, 1'b0);
      push_tick(32'h0000_1234, 1'b0);
      wait_drained();

      for (int phase = 0; phase < 12; phase++) begin
         write_reg(CSR_KP_GAIN, CSR_DATA_W'(pick_gain()));
         write_reg(CSR_KI_GAIN, ($urandom_range(0, 2) == 0) ?
                   CSR_DATA_W'(pick_gain()) : 32'd0);
         write_reg(CSR_KD_GAIN, CSR_DATA_W'(pick_gain()));
         write_reg(CSR_SLEW_STEP, ($urandom_range(0, 3) == 0) ?
                   (($urandom_range(0, 1) == 0) ? 32'd0 : 32'h7FFF) :
                   CSR_DATA_W'($urandom_range(1, 4000)));
         write_reg(CSR_TARGET, ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom());
         write_reg(CSR_STOP_BAND, ($urandom_range(0, 1) == 0) ?
                   32'd0 : CSR_DATA_W'($urandom_range(0, 65535)));
         write_reg(CSR_SWITCH_EN, $urandom_range(0, 1));
         no_idle = (phase % 4 == 3);
         for (int n = 0; n < 150; n++) begin
            hit = switch_en ? 1'b0 : 1'($urandom_range(0, 1));
            push_running_tick(hit);
         end
         wait_drained();
      end
      no_idle = 0;

      // The widest stop band ends the run; later ticks must stay frozen.
      write_reg(CSR_STOP_BAND, 32'h7FFF_FFFF);
      write_reg(CSR_SWITCH_EN, 32'd1);
      for (int n = 0; n < 30; n++) push_tick($urandom(), 1'($urandom_range(0, 1)));
      wait_drained();
      repeat (200) @(posedge clock);

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/psc_pkg.sv
sv/psc_div.sv
sv/psc_mul.sv
sv/pid_slew_clamp_controller.sv
sv/psc_checker.sv
tb/sv/pid_slew_clamp_controller_test.sv
